>>> hdl/bpcu_pkg.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Shared types and constants for the compensation pipeline and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcu_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_AC123 = 2'd0;
   localparam logic [1:0] REG_AC456 = 2'd1;
   localparam logic [1:0] REG_B12   = 2'd2;
   localparam logic [1:0] REG_MCMD  = 2'd3;

   // Result status codes.
   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_ZERO = 2'd1;
   localparam logic [1:0] STS_SAT  = 2'd2;

   // Widths of the two dividers.
   localparam int TDIV_NUM_W = 27;
   localparam int TDIV_DEN_W = 18;
   localparam int PDIV_NUM_W = 32;
   localparam int PDIV_DEN_W = 17;

   // Compensation constants of the integer datasheet form.
   localparam logic signed [12:0] B6_OFFSET = 13'sd4000;
   localparam logic [14:0]        B7_SCALE  = 15'd25000;
   localparam logic signed [12:0] P_K1      = 13'sd3038;
   localparam logic signed [14:0] P_K2      = -15'sd7357;
   localparam logic signed [12:0] P_K3      = 13'sd3791;
   localparam logic signed [18:0] X3_BIAS   = 19'sd32768;
   localparam logic [19:0]        P_MAX     = 20'hFFFFF;

   // Flags that follow an item once its temperature is known.
   typedef struct packed {
      logic signed [15:0] temp;
      logic               sat_t;
      logic               zero_t;
   } tflag_type;

   // Side data riding along the temperature divider.
   typedef struct packed {
      logic [16:0]        up;
      logic signed [16:0] x1;
      logic               qneg;
      logic               zero_t;
   } ttag_type;

   // Side data riding along the pressure divider.
   typedef struct packed {
      tflag_type tf;
      logic      b7_hi;
      logic      zero_p;
   } ptag_type;

endpackage

`default_nettype wire

>>> hdl/bpcu_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcu_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 17,
   parameter int TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [NUM_W-1:0]      out_quo,
   output logic [TAG_W-1:0]      out_tag
);

   logic             vld_s [NUM_W+1];
   logic [NUM_W-1:0] num_s [NUM_W+1];
   logic [DEN_W-1:0] den_s [NUM_W+1];
   logic [DEN_W-1:0] rem_s [NUM_W+1];
   logic [TAG_W-1:0] tag_s [NUM_W+1];

   assign vld_s[0] = in_valid;
   assign num_s[0] = in_num;
   assign den_s[0] = in_den;
   assign rem_s[0] = '0;
   assign tag_s[0] = in_tag;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             fits;
      logic             vld_ff;
      logic [NUM_W-1:0] num_ff;
      logic [DEN_W-1:0] den_ff;
      logic [DEN_W-1:0] rem_ff;
      logic [TAG_W-1:0] tag_ff;

      // Shift in the next dividend bit and try the subtraction.
      assign trial = {rem_s[k], num_s[k][NUM_W-1]};
      assign diff  = trial - {1'b0, den_s[k]};
      assign fits  = (trial >= {1'b0, den_s[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_s[k];
         end
      end

      // The dividend register fills with quotient bits from the bottom.
      always_ff @(posedge clock) begin
         num_ff <= {num_s[k][NUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         den_ff <= den_s[k];
         tag_ff <= tag_s[k];
      end

      assign vld_s[k+1] = vld_ff;
      assign num_s[k+1] = num_ff;
      assign den_s[k+1] = den_ff;
      assign rem_s[k+1] = rem_ff;
      assign tag_s[k+1] = tag_ff;
   end

   assign out_valid = vld_s[NUM_W];
   assign out_quo   = num_s[NUM_W];
   assign out_tag   = tag_s[NUM_W];

endmodule

`default_nettype wire

>>> hdl/barometric_pressure_compensation_unit.sv
// Each accepted transaction shows its result with rsp_strobe high.
// Throughput: one transaction per cycle; busy stays low. The two 1-bit-per-stage
// dividers have 27 and 32 stages.
// Reset clears all valid bits and the calibration registers; results are not held off.
// ----------------------------------------------------------------------------
// Barometric pressure compensation unit
// Integer temperature and pressure compensation from calibration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_unit
   import bpcu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [15:0]         req_raw_temp,
   input  wire logic [23:0]         req_raw_pressure,
   output logic                     rsp_strobe,
   output logic signed [15:0]       rsp_temp_tenths_c,
   output logic [19:0]              rsp_pressure_pa,
   output logic [1:0]               rsp_status,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [63:0]         pwdata,
   output logic [63:0]              prdata,
   output logic                     pready
);

   // ------------------------------------------------------------------
   // Calibration registers.
   // ------------------------------------------------------------------
   logic [47:0] cal0_ff;
   logic [47:0] cal1_ff;
   logic [31:0] cal2_ff;
   logic [31:0] cal3_ff;
   logic [1:0]  csr_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:3];
   assign csr_wr  = psel & penable & pwrite;

   // Write a register at the access cycle of a write transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal0_ff <= '0;
         cal1_ff <= '0;
         cal2_ff <= '0;
         cal3_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_AC123: cal0_ff <= pwdata[47:0];
            REG_AC456: cal1_ff <= pwdata[47:0];
            REG_B12:   cal2_ff <= pwdata[31:0];
            REG_MCMD:  cal3_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (csr_idx)
         REG_AC123: prdata = {16'h0, cal0_ff};
         REG_AC456: prdata = {16'h0, cal1_ff};
         REG_B12:   prdata = {32'h0, cal2_ff};
         REG_MCMD:  prdata = {32'h0, cal3_ff};
         default:   prdata = '0;
      endcase
   end

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = $signed(cal0_ff[15:0]);
   assign ac2 = $signed(cal0_ff[31:16]);
   assign ac3 = $signed(cal0_ff[47:32]);
   assign ac4 = cal1_ff[15:0];
   assign ac5 = cal1_ff[31:16];
   assign ac6 = cal1_ff[47:32];
   assign b1  = $signed(cal2_ff[15:0]);
   assign b2  = $signed(cal2_ff[31:16]);
   assign mc  = $signed(cal3_ff[15:0]);
   assign md  = $signed(cal3_ff[31:16]);

   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Stage 1: UT - AC6.
   // ------------------------------------------------------------------
   logic               s1_vld_ff;
   logic signed [16:0] s1_d_ff;
   logic [16:0]        s1_up_ff;
   logic signed [16:0] s1_d_in;

   assign s1_d_in = $signed({1'b0, req_raw_temp}) - $signed({1'b0, ac6});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_d_ff  <= s1_d_in;
      s1_up_ff <= req_raw_pressure[23:7];
   end

   // ------------------------------------------------------------------
   // Stage 2: X1 = ((UT - AC6) * AC5) >> 15.
   // ------------------------------------------------------------------
   logic               s2_vld_ff;
   logic signed [16:0] s2_x1_ff;
   logic [16:0]        s2_up_ff;
   logic signed [33:0] s2_prod;

   assign s2_prod = s1_d_ff * $signed({1'b0, ac5});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_x1_ff <= s2_prod[31:15];
      s2_up_ff <= s1_up_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: operands of MC * 2048 / (X1 + MD) as magnitudes.
   // ------------------------------------------------------------------
   logic                  s3_vld_ff;
   logic [TDIV_NUM_W-1:0] s3_num_ff;
   logic [TDIV_DEN_W-1:0] s3_den_ff;
   ttag_type              s3_tag_ff;
   logic signed [26:0]    s3_num;
   logic signed [17:0]    s3_den;
   logic [26:0]           s3_num_mag;
   logic [17:0]           s3_den_mag;
   ttag_type              s3_tag_in;

   assign s3_num     = {mc, 11'b0};
   assign s3_den     = 18'(s2_x1_ff) + 18'(md);
   assign s3_num_mag = s3_num[26] ? 27'(-s3_num) : s3_num;
   assign s3_den_mag = s3_den[17] ? 18'(-s3_den) : s3_den;

   always_comb begin
      s3_tag_in.up     = s2_up_ff;
      s3_tag_in.x1     = s2_x1_ff;
      s3_tag_in.qneg   = s3_num[26] ^ s3_den[17];
      s3_tag_in.zero_t = (s3_den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_num_ff <= s3_num_mag;
      s3_den_ff <= s3_den_mag;
      s3_tag_ff <= s3_tag_in;
   end

   // Temperature divider.
   logic                  td_vld;
   logic [TDIV_NUM_W-1:0] td_quo;
   logic [$bits(ttag_type)-1:0] td_tag_raw;
   ttag_type              td_tag;

   bpcu_div #(
      .NUM_W (TDIV_NUM_W),
      .DEN_W (TDIV_DEN_W),
      .TAG_W ($bits(ttag_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_vld_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (td_vld),
      .out_quo   (td_quo),
      .out_tag   (td_tag_raw)
   );

   assign td_tag = td_tag_raw;

   // ------------------------------------------------------------------
   // Stage 4: B5 = X1 + X2.
   // ------------------------------------------------------------------
   logic               s4_vld_ff;
   logic signed [28:0] s4_b5_ff;
   logic [16:0]        s4_up_ff;
   logic               s4_zero_ff;
   logic signed [27:0] s4_qs;
   logic signed [27:0] s4_x2;

   assign s4_qs = $signed({1'b0, td_quo});

   always_comb begin
      if (td_tag.zero_t) begin
         s4_x2 = '0;
      end else if (td_tag.qneg) begin
         s4_x2 = -s4_qs;
      end else begin
         s4_x2 = s4_qs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= td_vld;
      end
   end

   always_ff @(posedge clock) begin
      s4_b5_ff   <= 29'(td_tag.x1) + 29'(s4_x2);
      s4_up_ff   <= td_tag.up;
      s4_zero_ff <= td_tag.zero_t;
   end

   // ------------------------------------------------------------------
   // Stage 5: temperature result and B6 = B5 - 4000.
   // ------------------------------------------------------------------
   logic               s5_vld_ff;
   logic signed [29:0] s5_b6_ff;
   logic [16:0]        s5_up_ff;
   tflag_type          s5_tf_ff;
   logic signed [29:0] s5_t_sum;
   logic signed [25:0] s5_t;
   tflag_type          s5_tf_in;

   assign s5_t_sum = 30'(s4_b5_ff) + 30'sd8;
   assign s5_t     = s5_t_sum[29:4];

   // Saturate the temperature to 16 bits.
   always_comb begin
      s5_tf_in.zero_t = s4_zero_ff;
      if (!s5_t[25] && (s5_t[24:15] != '0)) begin
         s5_tf_in.temp  = 16'sh7FFF;
         s5_tf_in.sat_t = 1'b1;
      end else if (s5_t[25] && (s5_t[24:15] != '1)) begin
         s5_tf_in.temp  = -16'sh8000;
         s5_tf_in.sat_t = 1'b1;
      end else begin
         s5_tf_in.temp  = s5_t[15:0];
         s5_tf_in.sat_t = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_b6_ff <= 30'(s4_b5_ff) - 30'(B6_OFFSET);
      s5_up_ff <= s4_up_ff;
      s5_tf_ff <= s5_tf_in;
   end

   // ------------------------------------------------------------------
   // Stage 6: B6^2 >> 12, AC2 * B6 >> 11, AC3 * B6 >> 13.
   // ------------------------------------------------------------------
   logic               s6_vld_ff;
   logic signed [19:0] s6_sq_ff;
   logic signed [20:0] s6_x2a_ff;
   logic signed [18:0] s6_x1c_ff;
   logic [16:0]        s6_up_ff;
   tflag_type          s6_tf_ff;
   logic signed [59:0] s6_sq;
   logic signed [45:0] s6_m2;
   logic signed [45:0] s6_m3;

   assign s6_sq = s5_b6_ff * s5_b6_ff;
   assign s6_m2 = ac2 * s5_b6_ff;
   assign s6_m3 = ac3 * s5_b6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_sq_ff  <= s6_sq[31:12];
      s6_x2a_ff <= s6_m2[31:11];
      s6_x1c_ff <= s6_m3[31:13];
      s6_up_ff  <= s5_up_ff;
      s6_tf_ff  <= s5_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 7: B2 * B6sq >> 11, B1 * B6sq >> 16.
   // ------------------------------------------------------------------
   logic               s7_vld_ff;
   logic signed [20:0] s7_x1a_ff;
   logic signed [20:0] s7_x2a_ff;
   logic signed [18:0] s7_x1c_ff;
   logic signed [15:0] s7_x2c_ff;
   logic [16:0]        s7_up_ff;
   tflag_type          s7_tf_ff;
   logic signed [35:0] s7_m1;
   logic signed [35:0] s7_m2;

   assign s7_m1 = b2 * s6_sq_ff;
   assign s7_m2 = b1 * s6_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_x1a_ff <= s7_m1[31:11];
      s7_x2c_ff <= s7_m2[31:16];
      s7_x2a_ff <= s6_x2a_ff;
      s7_x1c_ff <= s6_x1c_ff;
      s7_up_ff  <= s6_up_ff;
      s7_tf_ff  <= s6_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 8: B3 and X3.
   // ------------------------------------------------------------------
   logic               s8_vld_ff;
   logic signed [22:0] s8_b3_ff;
   logic signed [17:0] s8_x3_ff;
   logic [16:0]        s8_up_ff;
   tflag_type          s8_tf_ff;
   logic signed [22:0] s8_sum;
   logic signed [24:0] s8_v;
   logic signed [24:0] s8_vr;
   logic signed [19:0] s8_x3s;

   assign s8_sum = 23'($signed({ac1, 2'b00})) + 23'(s7_x1a_ff) + 23'(s7_x2a_ff);
   assign s8_v   = 25'($signed({s8_sum, 1'b0})) + 25'sd2;
   // Division by four that truncates toward zero.
   assign s8_vr  = s8_v[24] ? (s8_v + 25'sd3) : s8_v;
   assign s8_x3s = 20'(s7_x1c_ff) + 20'(s7_x2c_ff) + 20'sd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s8_b3_ff <= s8_vr[24:2];
      s8_x3_ff <= s8_x3s[19:2];
      s8_up_ff <= s7_up_ff;
      s8_tf_ff <= s7_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 9: B4 and B7.
   // ------------------------------------------------------------------
   logic        s9_vld_ff;
   logic [16:0] s9_b4_ff;
   logic [31:0] s9_b7_ff;
   tflag_type   s9_tf_ff;
   logic [31:0] s9_a;
   logic [47:0] s9_m4;
   logic [31:0] s9_diff;
   logic [46:0] s9_m7;

   assign s9_a    = 32'(19'(s8_x3_ff) + X3_BIAS);
   assign s9_m4   = s9_a * ac4;
   assign s9_diff = {15'b0, s8_up_ff} - 32'(s8_b3_ff);
   assign s9_m7   = s9_diff * B7_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s9_b4_ff <= s9_m4[31:15];
      s9_b7_ff <= s9_m7[31:0];
      s9_tf_ff <= s8_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 10: dividend for the pressure quotient.
   // ------------------------------------------------------------------
   logic                  s10_vld_ff;
   logic [PDIV_NUM_W-1:0] s10_num_ff;
   logic [PDIV_DEN_W-1:0] s10_den_ff;
   ptag_type              s10_tag_ff;
   ptag_type              s10_tag_in;

   always_comb begin
      s10_tag_in.tf     = s9_tf_ff;
      s10_tag_in.b7_hi  = s9_b7_ff[31];
      s10_tag_in.zero_p = (s9_b4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else begin
         s10_vld_ff <= s9_vld_ff;
      end
   end

   // Small B7 divides twice its value; large B7 doubles the quotient after.
   always_ff @(posedge clock) begin
      s10_num_ff <= s9_b7_ff[31] ? s9_b7_ff : {s9_b7_ff[30:0], 1'b0};
      s10_den_ff <= s9_b4_ff;
      s10_tag_ff <= s10_tag_in;
   end

   // Pressure divider.
   logic                  pd_vld;
   logic [PDIV_NUM_W-1:0] pd_quo;
   logic [$bits(ptag_type)-1:0] pd_tag_raw;
   ptag_type              pd_tag;

   bpcu_div #(
      .NUM_W (PDIV_NUM_W),
      .DEN_W (PDIV_DEN_W),
      .TAG_W ($bits(ptag_type))
   ) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s10_vld_ff),
      .in_num    (s10_num_ff),
      .in_den    (s10_den_ff),
      .in_tag    (s10_tag_ff),
      .out_valid (pd_vld),
      .out_quo   (pd_quo),
      .out_tag   (pd_tag_raw)
   );

   assign pd_tag = pd_tag_raw;

   // ------------------------------------------------------------------
   // Stage 11: raw pressure P.
   // ------------------------------------------------------------------
   logic               s11_vld_ff;
   logic signed [31:0] s11_p_ff;
   logic               s11_zero_ff;
   tflag_type          s11_tf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else begin
         s11_vld_ff <= pd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pd_tag.zero_p) begin
         s11_p_ff <= '0;
      end else if (pd_tag.b7_hi) begin
         s11_p_ff <= $signed({pd_quo[30:0], 1'b0});
      end else begin
         s11_p_ff <= $signed(pd_quo);
      end
      s11_zero_ff <= pd_tag.zero_p | pd_tag.tf.zero_t;
      s11_tf_ff   <= pd_tag.tf;
   end

   // ------------------------------------------------------------------
   // Stage 12: (P >> 8)^2 and -7357 * P >> 16.
   // ------------------------------------------------------------------
   logic               s12_vld_ff;
   logic signed [31:0] s12_sq_ff;
   logic signed [15:0] s12_x2_ff;
   logic signed [31:0] s12_p_ff;
   logic               s12_zero_ff;
   tflag_type          s12_tf_ff;
   logic signed [23:0] s12_ps;
   logic signed [47:0] s12_sq;
   logic signed [46:0] s12_m2;

   assign s12_ps = s11_p_ff[31:8];
   assign s12_sq = s12_ps * s12_ps;
   assign s12_m2 = s11_p_ff * P_K2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_vld_ff <= 1'b0;
      end else begin
         s12_vld_ff <= s11_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s12_sq_ff   <= s12_sq[31:0];
      s12_x2_ff   <= s12_m2[31:16];
      s12_p_ff    <= s11_p_ff;
      s12_zero_ff <= s11_zero_ff;
      s12_tf_ff   <= s11_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 13: X1 = (sq * 3038) >> 16.
   // ------------------------------------------------------------------
   logic               s13_vld_ff;
   logic signed [15:0] s13_x1_ff;
   logic signed [15:0] s13_x2_ff;
   logic signed [31:0] s13_p_ff;
   logic               s13_zero_ff;
   tflag_type          s13_tf_ff;
   logic signed [44:0] s13_m1;

   assign s13_m1 = s12_sq_ff * P_K1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_vld_ff <= 1'b0;
      end else begin
         s13_vld_ff <= s12_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s13_x1_ff   <= s13_m1[31:16];
      s13_x2_ff   <= s12_x2_ff;
      s13_p_ff    <= s12_p_ff;
      s13_zero_ff <= s12_zero_ff;
      s13_tf_ff   <= s12_tf_ff;
   end

   // ------------------------------------------------------------------
   // Stage 14: final pressure, clamping and status.
   // ------------------------------------------------------------------
   logic               out_vld_ff;
   logic signed [15:0] out_temp_ff;
   logic [19:0]        out_p_ff;
   logic [1:0]         out_sts_ff;
   logic signed [17:0] s14_s;
   logic signed [31:0] s14_p;
   logic [19:0]        s14_pc;
   logic               s14_sat_p;
   logic [1:0]         s14_sts;

   assign s14_s = 18'(s13_x1_ff) + 18'(s13_x2_ff) + 18'(P_K3);
   assign s14_p = s13_p_ff + 32'($signed(s14_s[17:4]));

   always_comb begin
      if (s14_p[31]) begin
         s14_pc    = '0;
         s14_sat_p = 1'b1;
      end else if (s14_p[30:20] != '0) begin
         s14_pc    = P_MAX;
         s14_sat_p = 1'b1;
      end else begin
         s14_pc    = s14_p[19:0];
         s14_sat_p = 1'b0;
      end
      if (s13_zero_ff) begin
         s14_sts = STS_ZERO;
      end else if (s14_sat_p | s13_tf_ff.sat_t) begin
         s14_sts = STS_SAT;
      end else begin
         s14_sts = STS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= s13_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_temp_ff <= s13_tf_ff.temp;
      out_p_ff    <= s14_pc;
      out_sts_ff  <= s14_sts;
   end

   assign rsp_strobe        = out_vld_ff;
   assign rsp_temp_tenths_c = out_temp_ff;
   assign rsp_pressure_pa   = out_p_ff;
   assign rsp_status        = out_sts_ff;

endmodule

`default_nettype wire
